>>> rtl/core/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, codes and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

   // default sizes, handed to the top level parameters
   localparam int CBC_RAM_DEPTH     = 131072;
   localparam int CBC_MAX_ROM_BANKS = 512;

   // port widths
   localparam int REQ_W = 24;
   localparam int RSP_W = 24;
   localparam int CFG_W = 18;
   localparam int IDX_W = 2;

   // configuration register indexes
   localparam logic [IDX_W-1:0] CFG_MAPPER_KIND = 2'd0;
   localparam logic [IDX_W-1:0] CFG_ROM_BANKS   = 2'd1;
   localparam logic [IDX_W-1:0] CFG_RAM_BYTES   = 2'd2;

   // mapper kinds
   localparam logic [2:0] MAP_NONE  = 3'd0;
   localparam logic [2:0] MAP_MBC1  = 3'd1;
   localparam logic [2:0] MAP_MBC1M = 3'd2;
   localparam logic [2:0] MAP_MBC2  = 3'd3;
   localparam logic [2:0] MAP_MBC3  = 3'd4;
   localparam logic [2:0] MAP_MBC5  = 3'd5;

   // bus address boundaries
   localparam logic [15:0] ADDR_RAM_BASE = 16'hA000;
   localparam logic [15:0] ADDR_ROM_LOW  = 16'h2000;
   localparam logic [15:0] ADDR_ROM_HIGH = 16'h3000;
   localparam logic [15:0] ADDR_UPPER    = 16'h4000;
   localparam logic [15:0] ADDR_MODE     = 16'h6000;

   // remainder unit
   localparam int MOD_W      = 18;
   localparam int MOD_STEPS  = 18;
   localparam int BANK_STEPS = 10;
   localparam int BANK_SHIFT = MOD_W - BANK_STEPS;
   localparam int CNT_W      = $clog2(MOD_STEPS + 1);

   // queue between front and back
   localparam int Q_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_CTRL,
      KIND_RAM_WR,
      KIND_RAM_RD
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [15:0]   address;
      logic [7:0]    data;
      logic [15:0]   offset;
   } item_type;

   typedef struct packed {
      logic             start;
      logic             narrow;
      logic [MOD_W-1:0] dividend;
      logic [MOD_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [MOD_W-1:0] remainder;
   } mod_rsp_type;

endpackage

>>> rtl/core/cbc_ram.sv
// ----------------------------------------------------------------------------
// cbc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one access per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/cbc_mod.sv
// ----------------------------------------------------------------------------
// cbc_mod
// Shared remainder unit, restoring form, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cbc_mod
   import cbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_rsp_type rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MOD_W-1:0] rem_ff, rem_in;
   logic [MOD_W-1:0] dvd_ff, dvd_in;
   logic [MOD_W-1:0] dsr_ff, dsr_in;

   logic [MOD_W:0] trial;
   logic [MOD_W:0] diff;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[MOD_W-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.narrow ? CNT_W'(BANK_STEPS) : CNT_W'(MOD_STEPS);
         rem_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
         dvd_in = {dvd_ff[MOD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

>>> rtl/core/cbc_front.sv
// ----------------------------------------------------------------------------
// cbc_front
// Request side: takes bus words and sorts them into control writes, RAM
// writes and RAM reads, with the RAM window offset worked out up front.
// ----------------------------------------------------------------------------
module cbc_front
   import cbc_pkg::*;
(
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // address [15:0], data [23:16]
   input  logic             req_tuser,  // operation: 0 bus write, 1 RAM read
   input  logic             q_full,
   output logic             q_push,
   output item_type         q_item
);

   logic [15:0] address;
   logic [7:0]  data;

   assign address = req_tdata[15:0];
   assign data    = req_tdata[23:16];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // classify the word
   always_comb begin
      q_item.address = address;
      q_item.data    = data;
      q_item.offset  = address - ADDR_RAM_BASE;
      if (req_tuser) begin
         q_item.kind = KIND_RAM_RD;
      end else if (address >= ADDR_RAM_BASE) begin
         q_item.kind = KIND_RAM_WR;
      end else begin
         q_item.kind = KIND_CTRL;
      end
   end

endmodule

>>> rtl/core/cbc_queue.sv
// ----------------------------------------------------------------------------
// cbc_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module cbc_queue
   import cbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_QW = $clog2(Q_DEPTH + 1);

   item_type          mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_QW'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/cbc_back.sv
// ----------------------------------------------------------------------------
// cbc_back
// Execution side: holds the mapper registers and configuration, carries
// out control writes and RAM accesses, and drives the response word.
// ----------------------------------------------------------------------------
module cbc_back
   import cbc_pkg::*;
#(
   parameter int RAM_DEPTH     = CBC_RAM_DEPTH,
   parameter int MAX_ROM_BANKS = CBC_MAX_ROM_BANKS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [IDX_W-1:0]             csr_index,
   input  logic [CFG_W-1:0]             csr_wdata,
   input  logic                         q_empty,
   input  item_type                     q_head,
   output logic                         q_pop,
   output mod_req_type                  mod_req,
   input  mod_rsp_type                  mod_rsp,
   output logic                         ram_en,
   output logic                         ram_we,
   output logic [$clog2(RAM_DEPTH)-1:0] ram_addr,
   output logic [7:0]                   ram_wdata,
   input  logic [7:0]                   ram_rdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_W-1:0]             rsp_tdata
);

   localparam int AW = $clog2(RAM_DEPTH);
   localparam logic [MOD_W-1:0] DEPTH_SZ = MOD_W'(RAM_DEPTH);
   localparam logic [9:0]       MAX_BANKS = 10'(MAX_ROM_BANKS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BANK,
      ST_DIV,
      ST_ACCESS,
      ST_CAPTURE,
      ST_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       mapper_ff, mapper_in;
   logic [9:0]       rom_banks_ff, rom_banks_in;
   logic [17:0]      ram_bytes_ff, ram_bytes_in;
   logic             ram_enable_ff, ram_enable_in;
   logic             mode_adv_ff, mode_adv_in;
   logic [7:0]       bank_low_ff, bank_low_in;
   logic [1:0]       bank_high_ff, bank_high_in;
   logic [7:0]       ram_bank_ff, ram_bank_in;
   logic [8:0]       cur_bank_ff, cur_bank_in;
   logic             written_ff, written_in;
   logic             pending_ff, pending_in;
   logic             finish_ff, finish_in;
   logic             div_bank_ff, div_bank_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   item_type         item_ff, item_in;
   logic [MOD_W-1:0] idx_ff, idx_in;
   logic [7:0]       rd_ff, rd_in;

   logic [MOD_W-1:0] ram_sz;
   logic [9:0]       bank_mod;
   logic [9:0]       bank_raw;
   logic [MOD_W-1:0] idx_raw;
   logic             ram_on;
   logic             is_mbc2;
   logic             clock_sel;
   logic             enable_hit;

   // sizes and bank number from the current registers
   always_comb begin
      ram_sz = (ram_bytes_ff > DEPTH_SZ) ? DEPTH_SZ : ram_bytes_ff;
      if (rom_banks_ff == '0) begin
         bank_mod = 10'd2;
      end else if (rom_banks_ff > MAX_BANKS) begin
         bank_mod = MAX_BANKS;
      end else begin
         bank_mod = rom_banks_ff;
      end
      unique case (mapper_ff)
         MAP_MBC1:  bank_raw = {3'b0, bank_high_ff, 5'b0} | {2'b0, bank_low_ff};
         MAP_MBC1M: bank_raw = {4'b0, bank_high_ff, 4'b0} | {6'b0, bank_low_ff[3:0]};
         MAP_MBC2:  bank_raw = {2'b0, bank_low_ff};
         MAP_MBC3:  bank_raw = {2'b0, bank_low_ff};
         MAP_MBC5:  bank_raw = {bank_high_ff, bank_low_ff};
         default:   bank_raw = 10'd1;
      endcase
      idx_raw    = {2'b0, item_ff.offset} + {1'b0, ram_bank_ff[3:0], 13'b0};
      ram_on     = (ram_bytes_ff != '0) && ram_enable_ff;
      is_mbc2    = (mapper_ff == MAP_MBC2);
      clock_sel  = (mapper_ff == MAP_MBC3) && (ram_bank_ff > 8'h03);
      enable_hit = (item_ff.data[3:0] == 4'hA);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mapper_in     = mapper_ff;
      rom_banks_in  = rom_banks_ff;
      ram_bytes_in  = ram_bytes_ff;
      ram_enable_in = ram_enable_ff;
      mode_adv_in   = mode_adv_ff;
      bank_low_in   = bank_low_ff;
      bank_high_in  = bank_high_ff;
      ram_bank_in   = ram_bank_ff;
      cur_bank_in   = cur_bank_ff;
      written_in    = written_ff;
      pending_in    = pending_ff;
      finish_in     = finish_ff;
      div_bank_in   = div_bank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      rd_in         = rd_ff;
      q_pop         = 1'b0;
      mod_req       = '0;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = idx_ff[AW-1:0];
      ram_wdata     = is_mbc2 ? {4'b0, item_ff.data[3:0]} : item_ff.data;

      unique case (state_ff)
         ST_IDLE: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               finish_in  = 1'b0;
               state_in   = ST_BANK;
            end else if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            rd_in = 8'hFF;
            unique case (item_ff.kind)
               KIND_CTRL: begin
                  // mapper register write
                  unique case (mapper_ff)
                     MAP_MBC1, MAP_MBC1M: begin
                        priority if (item_ff.address < ADDR_ROM_LOW) begin
                           ram_enable_in = enable_hit;
                        end else if (item_ff.address < ADDR_UPPER) begin
                           bank_low_in = (item_ff.data[4:0] == '0) ? 8'd1
                                       : {3'b0, item_ff.data[4:0]};
                        end else if (item_ff.address < ADDR_MODE) begin
                           bank_high_in = item_ff.data[1:0];
                           if (mode_adv_ff) begin
                              ram_bank_in = {6'b0, item_ff.data[1:0]};
                           end
                        end else begin
                           mode_adv_in = item_ff.data[0];
                           ram_bank_in = item_ff.data[0] ? {6'b0, bank_high_ff} : 8'd0;
                        end
                     end
                     MAP_MBC2: begin
                        if (item_ff.address < ADDR_UPPER) begin
                           if (item_ff.address[8]) begin
                              bank_low_in = (item_ff.data[3:0] == '0) ? 8'd1
                                          : {4'b0, item_ff.data[3:0]};
                           end else begin
                              ram_enable_in = enable_hit;
                           end
                        end
                     end
                     MAP_MBC3: begin
                        priority if (item_ff.address < ADDR_ROM_LOW) begin
                           ram_enable_in = enable_hit;
                        end else if (item_ff.address < ADDR_UPPER) begin
                           bank_low_in = (item_ff.data[6:0] == '0) ? 8'd1
                                       : {1'b0, item_ff.data[6:0]};
                        end else if (item_ff.address < ADDR_MODE) begin
                           ram_bank_in = item_ff.data;
                        end
                     end
                     MAP_MBC5: begin
                        priority if (item_ff.address < ADDR_ROM_LOW) begin
                           ram_enable_in = enable_hit;
                        end else if (item_ff.address < ADDR_ROM_HIGH) begin
                           bank_low_in = item_ff.data;
                        end else if (item_ff.address < ADDR_UPPER) begin
                           bank_high_in = {1'b0, item_ff.data[0]};
                        end else if (item_ff.address < ADDR_MODE) begin
                           ram_bank_in = {4'b0, item_ff.data[3:0]};
                        end
                     end
                     default: begin
                     end
                  endcase
                  if (mapper_ff >= MAP_MBC1 && mapper_ff <= MAP_MBC5) begin
                     finish_in = 1'b1;
                     state_in  = ST_BANK;
                  end else begin
                     state_in = ST_RESULT;
                  end
               end

               KIND_RAM_WR, KIND_RAM_RD: begin
                  // RAM access: gate, then map the offset onto the store
                  if (!ram_on) begin
                     state_in = ST_RESULT;
                  end else if (is_mbc2) begin
                     idx_in   = {9'b0, item_ff.offset[8:0]};
                     state_in = ST_ACCESS;
                  end else if (clock_sel) begin
                     state_in = ST_RESULT;
                  end else if (idx_raw >= ram_sz) begin
                     mod_req.start    = 1'b1;
                     mod_req.narrow   = 1'b0;
                     mod_req.dividend = idx_raw;
                     mod_req.divisor  = ram_sz;
                     div_bank_in      = 1'b0;
                     state_in         = ST_DIV;
                  end else begin
                     idx_in   = idx_raw;
                     state_in = ST_ACCESS;
                  end
               end

               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end

         ST_BANK: begin
            // bank number modulo bank count, top bits of the unit only
            mod_req.start    = 1'b1;
            mod_req.narrow   = 1'b1;
            mod_req.dividend = {bank_raw, BANK_SHIFT'(0)};
            mod_req.divisor  = {BANK_SHIFT'(0), bank_mod};
            div_bank_in      = 1'b1;
            state_in         = ST_DIV;
         end

         ST_DIV: begin
            if (mod_rsp.done) begin
               if (div_bank_ff) begin
                  cur_bank_in = mod_rsp.remainder[8:0];
                  state_in    = finish_ff ? ST_RESULT : ST_IDLE;
               end else begin
                  idx_in   = mod_rsp.remainder;
                  state_in = ST_ACCESS;
               end
            end
         end

         ST_ACCESS: begin
            ram_en = 1'b1;
            if (item_ff.kind == KIND_RAM_WR) begin
               ram_we     = 1'b1;
               written_in = 1'b1;
               state_in   = ST_RESULT;
            end else begin
               state_in = ST_CAPTURE;
            end
         end

         ST_CAPTURE: begin
            rd_in    = is_mbc2 ? (ram_rdata | 8'hF0) : ram_rdata;
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_W - 18)'(0), written_ff, cur_bank_ff, rd_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes, bank gets recomputed after mapper or count change
      if (csr_we) begin
         case (csr_index)
            CFG_MAPPER_KIND: begin
               mapper_in  = csr_wdata[2:0];
               pending_in = 1'b1;
            end
            CFG_ROM_BANKS: begin
               rom_banks_in = csr_wdata[9:0];
               pending_in   = 1'b1;
            end
            CFG_RAM_BYTES: begin
               ram_bytes_in = csr_wdata[17:0];
            end
            default: begin
            end
         endcase
      end
   end

   // state, mapper registers and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mapper_ff     <= MAP_NONE;
         rom_banks_ff  <= 10'd2;
         ram_bytes_ff  <= '0;
         ram_enable_ff <= 1'b0;
         mode_adv_ff   <= 1'b0;
         bank_low_ff   <= 8'd1;
         bank_high_ff  <= '0;
         ram_bank_ff   <= '0;
         cur_bank_ff   <= 9'd1;
         written_ff    <= 1'b0;
         pending_ff    <= 1'b1;
         finish_ff     <= 1'b0;
         div_bank_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         mapper_ff     <= mapper_in;
         rom_banks_ff  <= rom_banks_in;
         ram_bytes_ff  <= ram_bytes_in;
         ram_enable_ff <= ram_enable_in;
         mode_adv_ff   <= mode_adv_in;
         bank_low_ff   <= bank_low_in;
         bank_high_ff  <= bank_high_in;
         ram_bank_ff   <= ram_bank_in;
         cur_bank_ff   <= cur_bank_in;
         written_ff    <= written_in;
         pending_ff    <= pending_in;
         finish_ff     <= finish_in;
         div_bank_ff   <= div_bank_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // current word payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      rd_ff   <= rd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/cartridge_bank_controller_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_unit
// Memory bank controller for handheld console cartridges, with on-chip
// cartridge RAM.
//
// Each request word is a bus write or a RAM window read; each produces one
// response word with the read byte (0xFF for writes or when RAM is off or
// absent), the switchable ROM bank after the access and a sticky RAM written
// flag. Supported mappers: none, MBC1, MBC1 multicart, MBC2, MBC3 (no clock)
// and MBC5, picked by the mapper_kind register. A front stage classifies
// request words into a two-entry queue, so up to two words are taken while
// the back end is busy or a response waits. The back end handles one word at
// a time: a RAM access that falls inside the RAM size passes the exec and
// access states to the response register, with a capture state added for
// a read; a mapper register write reduces the bank number modulo the bank
// count on a shared one-bit-per-cycle remainder unit in 10 steps; a RAM
// access whose banked index runs past the RAM size is reduced modulo the
// RAM size in 18 steps of the same unit. Writing mapper_kind or rom_banks,
// and leaving reset, starts a bank recompute before the next word is taken.
// Cartridge RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_unit
   import cbc_pkg::*;
#(
   parameter int RAM_DEPTH     = CBC_RAM_DEPTH,
   parameter int MAX_ROM_BANKS = CBC_MAX_ROM_BANKS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // address [15:0], data [23:16]
   input  logic             req_tuser,  // operation: 0 bus write, 1 RAM read
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // read_data [7:0], rom_bank [16:8],
                                        // ram_dirty [17], zero [23:18]
);

   localparam int AW = $clog2(RAM_DEPTH);

   logic          q_push;
   item_type      q_push_item;
   logic          q_pop;
   item_type      q_head;
   logic          q_full;
   logic          q_empty;
   mod_req_type   mod_req;
   mod_rsp_type   mod_rsp;
   logic          ram_en;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   // request classification
   cbc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   // decoupling queue
   cbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // execution
   cbc_back #(
      .RAM_DEPTH     (RAM_DEPTH),
      .MAX_ROM_BANKS (MAX_ROM_BANKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .mod_req    (mod_req),
      .mod_rsp    (mod_rsp),
      .ram_en     (ram_en),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shared remainder unit
   cbc_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   // cartridge RAM
   cbc_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

`ifndef SYNTHESIS
   // a full queue holds off the request side
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("request taken while queue full");

   // no word leaves the queue while the remainder unit is busy
   a_mod_exclusive: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.busy |-> !q_pop)
      else $error("queue popped during remainder run");

   // a mapper or bank count change is followed by a bank recompute first
   a_refresh_first: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == CFG_MAPPER_KIND || csr_index == CFG_ROM_BANKS))
      |=> !q_pop)
      else $error("word taken before bank recompute");
`endif

endmodule
